FILE: sv/rgbycc_pkg.sv
// ----------------------------------------------------------------------------
// rgbycc_pkg
// Shared constants, types and helpers for the RGB to YCbCr 2x2 downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbycc_pkg;

  // Frame size limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  // Field widths
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 12;
  localparam int PSUM_W  = 9;    // sum of a horizontal pixel pair, per channel
  localparam int BSUM_W  = 10;   // sum of a 2x2 block, per channel
  localparam int BLK_W   = 10;   // block_col / block_row
  localparam int COEF_W  = 16;
  localparam int PROD_W  = BSUM_W + COEF_W;
  localparam int ACC_W   = PROD_W + 2;

  // Register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

  // Q16 coefficients, magnitudes only; signs are applied at the accumulator
  localparam logic [COEF_W-1:0] K_Y_R  = COEF_W'(16843);
  localparam logic [COEF_W-1:0] K_Y_G  = COEF_W'(33030);
  localparam logic [COEF_W-1:0] K_Y_B  = COEF_W'(6423);
  localparam logic [COEF_W-1:0] K_CB_R = COEF_W'(9699);
  localparam logic [COEF_W-1:0] K_CB_G = COEF_W'(19071);
  localparam logic [COEF_W-1:0] K_CB_B = COEF_W'(28770);
  localparam logic [COEF_W-1:0] K_CR_R = COEF_W'(28770);
  localparam logic [COEF_W-1:0] K_CR_G = COEF_W'(24117);
  localparam logic [COEF_W-1:0] K_CR_B = COEF_W'(4653);

  // Offsets pre-scaled by 2^18, plus half an LSB for round to nearest
  localparam logic signed [ACC_W-1:0] OFS_Y = ACC_W'(16 * 262144 + 131072);
  localparam logic signed [ACC_W-1:0] OFS_C = ACC_W'(128 * 262144 + 131072);

  typedef struct packed {
    logic [BLK_W-1:0] col;
    logic [BLK_W-1:0] row;
    logic             last;
  } blk_info_t;

  typedef struct packed {
    logic [PSUM_W-1:0] r;
    logic [PSUM_W-1:0] g;
    logic [PSUM_W-1:0] b;
  } pair_t;

  // Drop the fraction, clamp to 0..255
  function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-19:0] q;
    q = acc[ACC_W-1:18];
    if (acc[ACC_W-1])
      return '0;
    else if (q > (ACC_W-18)'(255))
      return PIX_W'(255);
    else
      return q[PIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/rgb_to_ycbcr_2x2_downsample.sv
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_2x2_downsample
// Raster RGB pixels in, one BT.601 studio-range Y/Cb/Cr triple per 2x2 block
// out. Pair sums of even rows wait in a line memory for the odd row below.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+--------------------------------
//  s_*     | in  | s_tvalid / s_tready      | s_tdata: red, green, blue
//  m_*     | out | m_tvalid / m_tready      | m_tdata: luma, blue_diff,
//          |     |                          |   red_diff, block_col, block_row
//          |     |                          | m_tlast: last_block
//  cfg_*   | in  | cfg_we (no wait)         | cfg_index, cfg_wdata
//
//  One pixel is taken per clock unless the output is stalled. A block's
//  result passes stages 1 to 3 and the output register. The line memory is
//  read and written only on the accept edge, and a read of an entry always
//  follows its write by at least one item, so no forwarding is needed.
//  rst (synchronous) clears counters and pipeline valids and loads the size
//  registers with 640 x 480; the line memory is not cleared. A full output
//  register (m_tvalid high, m_tready low) holds the whole pipeline and drops
//  s_tready until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_ycbcr_2x2_downsample (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [23:0]                   s_tdata,   // red, green, blue
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [47:0]                        m_tdata,   // luma, blue_diff, red_diff,
                                                        // block_col, block_row, zero pad
  output logic                               m_tlast,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [rgbycc_pkg::CFG_W-1:0]  cfg_wdata
);
  import rgbycc_pkg::*;

  // Configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Last position: zero acts as one, oversize acts as the maximum
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;

  always_comb begin
    if (frame_width == '0)
      col_last = '0;
    else if (frame_width > CFG_W'(MAX_WIDTH))
      col_last = COL_W'(MAX_WIDTH - 1);
    else
      col_last = COL_W'(frame_width - CFG_W'(1));
    if (frame_height == '0)
      row_last = '0;
    else if (frame_height > CFG_W'(MAX_HEIGHT))
      row_last = ROW_W'(MAX_HEIGHT - 1);
    else
      row_last = ROW_W'(frame_height - CFG_W'(1));
  end

  // Pipeline control: every stage advances when the output slot frees up
  logic advance;
  logic accept;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;

  // Stage 0: counters, pair sums, line memory access
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  pair_t            pair_sums;
  pair_t            pair_next;
  logic             last_col;
  logic             last_row;
  logic             pair_done;
  logic [PIX_W-1:0] in_r, in_g, in_b;
  logic [LINE_AW-1:0] line_addr;
  logic             line_wr;
  logic             line_rd;
  logic             emit;

  assign in_r = s_tdata[PIX_W-1:0];
  assign in_g = s_tdata[2*PIX_W-1:PIX_W];
  assign in_b = s_tdata[3*PIX_W-1:2*PIX_W];

  assign last_col  = column_count >= col_last;
  assign last_row  = row_count >= row_last;
  assign line_addr = LINE_AW'(column_count >> 1);

  always_comb begin
    if (!column_count[0]) begin
      pair_done = last_col;
      if (last_col) begin
        // replicate the odd last column
        pair_next.r = {in_r, 1'b0};
        pair_next.g = {in_g, 1'b0};
        pair_next.b = {in_b, 1'b0};
      end else begin
        pair_next.r = PSUM_W'(in_r);
        pair_next.g = PSUM_W'(in_g);
        pair_next.b = PSUM_W'(in_b);
      end
    end else begin
      pair_done   = 1'b1;
      pair_next.r = pair_sums.r + PSUM_W'(in_r);
      pair_next.g = pair_sums.g + PSUM_W'(in_g);
      pair_next.b = pair_sums.b + PSUM_W'(in_b);
    end
    line_wr = accept && pair_done && !row_count[0] && !last_row;
    line_rd = accept && pair_done && row_count[0];
    emit    = pair_done && (row_count[0] || last_row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      pair_sums    <= '0;
    end else if (accept) begin
      pair_sums <= pair_next;
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // Line memory: pair sums of the last even row, one entry per block column
  pair_t line_mem [LINE_DEPTH];
  pair_t line_rdata;

  always_ff @(posedge clk) begin
    if (line_wr)
      line_mem[line_addr] <= pair_next;
  end

  always_ff @(posedge clk) begin
    if (line_rd)
      line_rdata <= line_mem[line_addr];
  end

  // Stage 1: hold pair sums until the line data lands
  logic      s1_valid;
  logic      s1_use_line;
  pair_t     s1_pair;
  blk_info_t s1_info;

  always_ff @(posedge clk) begin
    if (rst)
      s1_valid <= 1'b0;
    else if (advance)
      s1_valid <= accept && emit;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_use_line  <= row_count[0];
      s1_pair      <= pair_next;
      s1_info.col  <= BLK_W'(column_count >> 1);
      s1_info.row  <= BLK_W'(row_count >> 1);
      s1_info.last <= last_col && last_row;
    end
  end

  // Stage 2: block sums; an odd last row is counted twice
  logic              s2_valid;
  logic [BSUM_W-1:0] s2_r, s2_g, s2_b;
  blk_info_t         s2_info;

  always_ff @(posedge clk) begin
    if (rst)
      s2_valid <= 1'b0;
    else if (advance)
      s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_info <= s1_info;
      if (s1_use_line) begin
        s2_r <= BSUM_W'(s1_pair.r) + BSUM_W'(line_rdata.r);
        s2_g <= BSUM_W'(s1_pair.g) + BSUM_W'(line_rdata.g);
        s2_b <= BSUM_W'(s1_pair.b) + BSUM_W'(line_rdata.b);
      end else begin
        s2_r <= {s1_pair.r, 1'b0};
        s2_g <= {s1_pair.g, 1'b0};
        s2_b <= {s1_pair.b, 1'b0};
      end
    end
  end

  // Stage 3: coefficient products, one small multiplier each
  logic              s3_valid;
  logic [PROD_W-1:0] p_y_r, p_y_g, p_y_b;
  logic [PROD_W-1:0] p_cb_r, p_cb_g, p_cb_b;
  logic [PROD_W-1:0] p_cr_r, p_cr_g, p_cr_b;
  blk_info_t         s3_info;

  always_ff @(posedge clk) begin
    if (rst)
      s3_valid <= 1'b0;
    else if (advance)
      s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_info <= s2_info;
      p_y_r   <= PROD_W'(s2_r) * PROD_W'(K_Y_R);
      p_y_g   <= PROD_W'(s2_g) * PROD_W'(K_Y_G);
      p_y_b   <= PROD_W'(s2_b) * PROD_W'(K_Y_B);
      p_cb_r  <= PROD_W'(s2_r) * PROD_W'(K_CB_R);
      p_cb_g  <= PROD_W'(s2_g) * PROD_W'(K_CB_G);
      p_cb_b  <= PROD_W'(s2_b) * PROD_W'(K_CB_B);
      p_cr_r  <= PROD_W'(s2_r) * PROD_W'(K_CR_R);
      p_cr_g  <= PROD_W'(s2_g) * PROD_W'(K_CR_G);
      p_cr_b  <= PROD_W'(s2_b) * PROD_W'(K_CR_B);
    end
  end

  // Stage 4: accumulate with offset and rounding, clamp, output register
  logic signed [ACC_W-1:0] acc_y, acc_cb, acc_cr;
  logic [PIX_W-1:0]        luma, blue_diff, red_diff;
  blk_info_t               out_info;

  always_comb begin
    acc_y  = $signed(ACC_W'(p_y_r)) + $signed(ACC_W'(p_y_g))
           + $signed(ACC_W'(p_y_b)) + OFS_Y;
    acc_cb = $signed(ACC_W'(p_cb_b)) - $signed(ACC_W'(p_cb_r))
           - $signed(ACC_W'(p_cb_g)) + OFS_C;
    acc_cr = $signed(ACC_W'(p_cr_r)) - $signed(ACC_W'(p_cr_g))
           - $signed(ACC_W'(p_cr_b)) + OFS_C;
  end

  always_ff @(posedge clk) begin
    if (rst)
      m_tvalid <= 1'b0;
    else if (advance)
      m_tvalid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      luma      <= clamp_byte(acc_y);
      blue_diff <= clamp_byte(acc_cb);
      red_diff  <= clamp_byte(acc_cr);
      out_info  <= s3_info;
    end
  end

  assign m_tdata = {4'b0, out_info.row, out_info.col, red_diff, blue_diff, luma};
  assign m_tlast = out_info.last;

endmodule

`default_nettype wire

FILE: tb/ycbcr_block_checker.sv
// ----------------------------------------------------------------------------
// ycbcr_block_checker
// Watches the pixel, block and register channels of the downsampler, works
// out the Y/Cb/Cr block that each pixel closes and compares it with the
// block that leaves the output channel, oldest first.
// ----------------------------------------------------------------------------

module ycbcr_block_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [23:0]                      s_tdata,   // red, green, blue
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [47:0]                      m_tdata,   // luma, blue_diff, red_diff,
                                                      // block_col, block_row, pad
  input  logic                             m_tlast,   // last_block
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [rgbycc_pkg::CFG_W-1:0]     cfg_wdata,
  output int                               fail_count,
  output int                               outstanding,
  output int                               blocks_checked
);

  localparam int     MAX_REPORTS = 10;
  localparam longint Y_OFFSET    = 16;
  localparam longint C_OFFSET    = 128;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic [9:0] col;
    logic [9:0] row;
    logic       last;
  } ycc_block_t;

  logic [rgbycc_pkg::CFG_W-1:0] width_reg;
  logic [rgbycc_pkg::CFG_W-1:0] height_reg;
  int                           col_pos;
  int                           row_pos;
  rgbycc_pkg::pair_t            pair_acc;
  rgbycc_pkg::pair_t            line_mem [rgbycc_pkg::LINE_DEPTH];
  ycc_block_t                   block_q [$];
  int                           fails;
  int                           checked;

  function automatic int clip_size(logic [rgbycc_pkg::CFG_W-1:0] raw, int lim);
    if (raw == 0) return 1;
    return (int'(raw) > lim) ? lim : int'(raw);
  endfunction

  // Weighted sum of the block's channel sums in Q18, rounded half up, clamped
  function automatic logic [7:0] to_byte(longint kr, longint kg, longint kb,
                                         longint sr, longint sg, longint sb,
                                         longint offset);
    longint acc;
    acc = kr * sr + kg * sg + kb * sb + (offset <<< 18) + (longint'(1) <<< 17);
    if (acc < 0) return 8'd0;
    acc = acc >>> 18;
    return (acc > 255) ? 8'd255 : acc[7:0];
  endfunction

  task automatic predict_pixel(logic [23:0] px);
    int                w;
    int                h;
    bit                last_col;
    bit                last_row;
    bit                pair_done;
    bit                emit;
    int                bc;
    longint            sr;
    longint            sg;
    longint            sb;
    logic [8:0]        r;
    logic [8:0]        g;
    logic [8:0]        b;
    rgbycc_pkg::pair_t held;
    ycc_block_t        blk;
    w = clip_size(width_reg, rgbycc_pkg::MAX_WIDTH);
    h = clip_size(height_reg, rgbycc_pkg::MAX_HEIGHT);
    r = {1'b0, px[7:0]};
    g = {1'b0, px[15:8]};
    b = {1'b0, px[23:16]};
    last_col = col_pos >= w - 1;
    last_row = row_pos >= h - 1;
    pair_done = 1'b0;
    emit = 1'b0;

    // Build the horizontal pair; a lone last pixel counts twice
    if (col_pos % 2 == 0) begin
      if (last_col) begin
        pair_acc = '{r: r << 1, g: g << 1, b: b << 1};
        pair_done = 1'b1;
      end else begin
        pair_acc = '{r: r, g: g, b: b};
      end
    end else begin
      pair_acc = '{r: pair_acc.r + r, g: pair_acc.g + g, b: pair_acc.b + b};
      pair_done = 1'b1;
    end

    if (pair_done) begin
      bc = col_pos >> 1;
      sr = pair_acc.r;
      sg = pair_acc.g;
      sb = pair_acc.b;
      if (row_pos % 2 == 0) begin
        if (last_row) begin
          // Lone last row: its pair counts twice
          sr = sr * 2;
          sg = sg * 2;
          sb = sb * 2;
          emit = 1'b1;
        end else begin
          line_mem[bc] = pair_acc;
        end
      end else begin
        held = line_mem[bc];
        sr = sr + held.r;
        sg = sg + held.g;
        sb = sb + held.b;
        emit = 1'b1;
      end
    end

    if (emit) begin
      blk.luma = to_byte(rgbycc_pkg::K_Y_R, rgbycc_pkg::K_Y_G, rgbycc_pkg::K_Y_B,
                         sr, sg, sb, Y_OFFSET);
      blk.cb   = to_byte(-longint'(rgbycc_pkg::K_CB_R), -longint'(rgbycc_pkg::K_CB_G),
                         rgbycc_pkg::K_CB_B, sr, sg, sb, C_OFFSET);
      blk.cr   = to_byte(rgbycc_pkg::K_CR_R, -longint'(rgbycc_pkg::K_CR_G),
                         -longint'(rgbycc_pkg::K_CR_B), sr, sg, sb, C_OFFSET);
      blk.col  = 10'(bc);
      blk.row  = 10'(row_pos >> 1);
      blk.last = last_col && last_row;
      block_q.push_back(blk);
    end

    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic check_block(logic [47:0] data, logic last_bit);
    ycc_block_t got;
    ycc_block_t want;
    got = '{luma: data[7:0], cb: data[15:8], cr: data[23:16],
            col: data[33:24], row: data[43:34], last: last_bit};
    checked++;
    if (block_q.size() == 0) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("[%0t] block with nothing pending: Y %0d Cb %0d Cr %0d col %0d row %0d last %0b",
                 $realtime, got.luma, got.cb, got.cr, got.col, got.row, got.last);
    end else begin
      want = block_q.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("[%0t] block mismatch\n  expected Y %0d Cb %0d Cr %0d col %0d row %0d last %0b\n  actual   Y %0d Cb %0d Cr %0d col %0d row %0d last %0b",
                   $realtime, want.luma, want.cb, want.cr, want.col, want.row, want.last,
                   got.luma, got.cb, got.cr, got.col, got.row, got.last);
      end
    end
  endtask

  initial begin
    fails = 0;
    checked = 0;
    fail_count = 0;
    outstanding = 0;
    blocks_checked = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      width_reg = rgbycc_pkg::FRAME_WIDTH_RST;
      height_reg = rgbycc_pkg::FRAME_HEIGHT_RST;
      col_pos = 0;
      row_pos = 0;
      pair_acc = '0;
      block_q.delete();
    end else begin
      if (m_tvalid && m_tready)
        check_block(m_tdata, m_tlast);
      if (cfg_we) begin
        if (cfg_index == rgbycc_pkg::REG_FRAME_WIDTH)
          width_reg = cfg_wdata;
        else
          height_reg = cfg_wdata;
      end
      if (s_tvalid && s_tready)
        predict_pixel(s_tdata);
    end
    outstanding <= block_q.size();
    fail_count <= fails;
    blocks_checked <= checked;
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the RGB to YCbCr 2x2 downsampler. Sends frames of
// many sizes with random idle gaps on the pixel side and random stalls on the
// block side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb;

  // Hard stop for a hung run; the slowest legal run is far below this
  localparam int LIMIT        = 1_000_000;
  // Cycles to let the pipeline settle once nothing is pending
  localparam int DRAIN        = 8;
  localparam int RANDOM_ITEMS = 1100;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic [23:0]                   s_tdata   = '0;     // red, green, blue
  logic                          m_tready  = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic                          cfg_index = rgbycc_pkg::REG_FRAME_WIDTH;
  logic [rgbycc_pkg::CFG_W-1:0]  cfg_wdata = '0;
  logic                          s_tready;
  logic                          m_tvalid;
  logic [47:0]                   m_tdata;             // luma, blue_diff, red_diff,
                                                      // block_col, block_row, pad
  logic                          m_tlast;             // last_block

  int fail_count;
  int outstanding;
  int blocks_checked;
  int pixels_sent;
  int frames_sent;
  bit steady_source;    // when set, the pixel side sends without gaps

  initial begin
    forever #5 clk = ~clk;
  end

  rgb_to_ycbcr_2x2_downsample dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ycbcr_block_checker block_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .blocks_checked (blocks_checked)
  );

  // Idle length: mostly none or short, now and then a long one
  function automatic int pause_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 9);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [23:0] pix(int r, int g, int b);
    return {8'(b), 8'(g), 8'(r)};
  endfunction

  // Lean on the channel extremes now and then, otherwise any value
  function automatic logic [7:0] random_channel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic logic [23:0] random_pixel();
    return {random_channel(), random_channel(), random_channel()};
  endfunction

  // Size the block actually uses for a raw register value
  function automatic int eff_size(int raw, int lim);
    if (raw == 0) return 1;
    return (raw > lim) ? lim : raw;
  endfunction

  // Present one item and hold it until the block takes it
  task automatic send_pixel(logic [23:0] px);
    int gap;
    gap = steady_source ? 0 : pause_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= 24'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_pixels(int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // Drop valid, wait for every pending block, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= rgbycc_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Start a new frame geometry; only legal with the block idle
  task automatic configure(int width_raw, int height_raw);
    settle();
    write_reg(rgbycc_pkg::REG_FRAME_WIDTH, width_raw);
    write_reg(rgbycc_pkg::REG_FRAME_HEIGHT, height_raw);
    frames_sent++;
    steady_source = ($urandom_range(0, 3) == 0);
  endtask

  // Block side: ready runs broken by stalls; sometimes a long stretch with none
  initial begin
    int run;
    int stall;
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        run = $urandom_range(150, 400);
        stall = 0;
      end else begin
        run = $urandom_range(1, 12);
        stall = pause_len();
      end
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Watchdog: give up on a hung run
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d blocks pending", LIMIT, outstanding);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int w;
    int h;
    int w_raw;
    int h_raw;
    int w2_raw;
    int h2_raw;
    int cut_row;
    int tail;
    int random_sent;
    pixels_sent = 0;
    frames_sent = 0;
    random_sent = 0;
    steady_source = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // --- Directed part ---------------------------------------------------
    // 3x3 frame: odd last column and odd last row both replicate, with
    // black, white, primaries, secondaries and mid grey as the pixels.
    configure(3, 3);
    send_pixel(pix(0, 0, 0));
    send_pixel(pix(255, 255, 255));
    send_pixel(pix(255, 0, 0));
    send_pixel(pix(0, 255, 0));
    send_pixel(pix(0, 0, 255));
    send_pixel(pix(255, 255, 0));
    send_pixel(pix(0, 255, 255));
    send_pixel(pix(255, 0, 255));
    send_pixel(pix(128, 128, 128));

    // Zero-sized registers act as 1: a single pixel fills the whole block
    configure(0, 0);
    send_pixel(pix(255, 255, 255));

    // Shrink mid-frame: the column counter is past the new width, so the
    // next pixel closes the row; then shrink the height under the row count
    configure(6, 4);
    send_pixels(4);
    settle();
    write_reg(rgbycc_pkg::REG_FRAME_WIDTH, 2);
    send_pixel(pix(255, 0, 255));
    send_pixels(2);
    settle();
    write_reg(rgbycc_pkg::REG_FRAME_HEIGHT, 1);
    send_pixels(2);

    // --- Random frames ---------------------------------------------------
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w_raw = 0;
        7, 8:    w_raw = $urandom_range(13, 64);
        default: w_raw = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       h_raw = 0;
        8, 9:    h_raw = $urandom_range(7, 12);
        default: h_raw = $urandom_range(1, 6);
      endcase
      configure(w_raw, h_raw);
      w = eff_size(w_raw, rgbycc_pkg::MAX_WIDTH);
      h = eff_size(h_raw, rgbycc_pkg::MAX_HEIGHT);

      if (h >= 2 && $urandom_range(0, 3) == 0) begin
        // Change size at a row boundary. Only narrow the width, so an odd
        // row never reads a line entry the row above did not fill; the
        // height may land under the current row, which then ends the frame.
        cut_row = $urandom_range(1, h - 1);
        send_pixels(cut_row * w);
        settle();
        w2_raw = $urandom_range(1, w);
        if (w2_raw == 1 && $urandom_range(0, 1) == 1) w2_raw = 0;
        h2_raw = $urandom_range(1, h + 3);
        write_reg(rgbycc_pkg::REG_FRAME_WIDTH, w2_raw);
        write_reg(rgbycc_pkg::REG_FRAME_HEIGHT, h2_raw);
        w = eff_size(w2_raw, rgbycc_pkg::MAX_WIDTH);
        h = eff_size(h2_raw, rgbycc_pkg::MAX_HEIGHT);
        tail = (h - 1 <= cut_row) ? w : (h - cut_row) * w;
        send_pixels(tail);
        random_sent += cut_row * eff_size(w_raw, rgbycc_pkg::MAX_WIDTH) + tail;
      end else begin
        send_pixels(w * h);
        random_sent += w * h;
      end
    end

    // --- Oversize registers ----------------------------------------------
    // Width register above the limit acts as 2048: a few pixels into the
    // single row, narrow the width so the column counter lies past the last
    // position and the next pixel closes the frame.
    configure(4095, 1);
    send_pixels(6);
    settle();
    write_reg(rgbycc_pkg::REG_FRAME_WIDTH, 1);
    send_pixel(pix(10, 200, 30));
    // Height register above the limit acts as 2048: a few one-pixel rows,
    // then drop the height so the odd row in progress ends the frame.
    configure(1, 4095);
    send_pixels(5);
    settle();
    write_reg(rgbycc_pkg::REG_FRAME_HEIGHT, 1);
    send_pixel(pix(240, 16, 128));

    settle();

    $display("Covered %0d pixels in %0d frames, %0d blocks checked,", pixels_sent,
             frames_sent, blocks_checked);
    $display("sizes from 1x1 up to 64x12, zero and oversize registers, size changes in frames.");
    if (fail_count == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: rgb_to_ycbcr_2x2_downsample.f
sv/rgbycc_pkg.sv
sv/rgb_to_ycbcr_2x2_downsample.sv
tb/ycbcr_block_checker.sv
tb/tb.sv
